// ===== hdl/semiplanar_yuv_block_to_rgb_macros.svh =====
// Assertion macros shared by the RTL of the YUV block to RGB converter.
// No dependencies; included by the files that carry assertions.
`ifndef SEMIPLANAR_YUV_BLOCK_TO_RGB_MACROS_SVH
`define SEMIPLANAR_YUV_BLOCK_TO_RGB_MACROS_SVH

// a implies c at the same edge
`define SYB_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed: a |-> c");

// a implies c at the following edge
`define SYB_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed: a |=> c");

`endif

// ===== hdl/syb_pkg.sv =====
// Types, coefficients and the channel clamp of the YUV 4:2:0 block to RGB888 converter.
// No dependencies.
`default_nettype none

package syb_pkg;

  localparam int unsigned NumPix = 4;

  localparam logic [7:0]         LumaOffset = 8'd16;
  localparam logic [16:0]        LumaCoef   = 17'd298;
  localparam logic [16:0]        LumaMax    = 17'd71222;  // 298 * (255 - 16)
  localparam logic signed [18:0] RoundBias  = 19'sd128;
  localparam logic signed [18:0] CoefRv     = 19'sd409;
  localparam logic signed [18:0] CoefGu     = 19'sd100;
  localparam logic signed [18:0] CoefGv     = 19'sd208;
  localparam logic signed [18:0] CoefBu     = 19'sd516;
  localparam logic signed [18:0] ChanSat    = 19'sd65535;

  // raw word as taken from the input port
  typedef struct packed {
    logic [NumPix-1:0][7:0] luma;
    logic [7:0]             chroma_first;
    logic [7:0]             chroma_second;
  } raw_t;

  // after offset removal and chroma ordering
  typedef struct packed {
    logic [NumPix-1:0][7:0] luma;
    logic signed [8:0]      u;
    logic signed [8:0]      v;
  } prep_t;

  // scaled terms
  typedef struct packed {
    logic [NumPix-1:0][16:0] luma_term;
    logic signed [16:0]      term_r;
    logic signed [16:0]      term_g;
    logic signed [17:0]      term_b;
  } mult_t;

  typedef struct packed {
    logic [NumPix-1:0][23:0] rgb;
  } pix_t;

  function automatic logic [7:0] clamp_chan(input logic signed [18:0] s);
    logic [7:0] c;
    if (s <= 19'sd0) begin
      c = 8'h00;
    end else if (s >= ChanSat) begin
      c = 8'hFF;
    end else begin
      c = s[15:8];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/syb_prep.sv =====
// First pipeline stage: luma offset with floor at zero, chroma centring and U/V ordering.
// Depends on syb_pkg.
`default_nettype none

module syb_prep (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          chroma_order,
  input  logic          s_valid,
  output logic          s_ready,
  input  syb_pkg::raw_t s_data,
  output logic          m_valid,
  input  logic          m_ready,
  output syb_pkg::prep_t m_data
);
  import syb_pkg::*;

  logic  valid_r;
  prep_t data_r;
  prep_t data_nxt;
  logic signed [8:0] c0;
  logic signed [8:0] c1;

  assign s_ready = !valid_r || m_ready;

  always_comb begin
    c0 = $signed({1'b0, s_data.chroma_first}) - 9'sd128;
    c1 = $signed({1'b0, s_data.chroma_second}) - 9'sd128;
    for (int i = 0; i < NumPix; i++) begin
      data_nxt.luma[i] = (s_data.luma[i] > LumaOffset) ? s_data.luma[i] - LumaOffset : 8'd0;
    end
    // NV21 carries V first
    if (chroma_order) begin
      data_nxt.v = c0;
      data_nxt.u = c1;
    end else begin
      data_nxt.u = c0;
      data_nxt.v = c1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

`default_nettype wire

// ===== hdl/syb_mult.sv =====
// Second pipeline stage: luma scaling and the BT.601 chroma terms.
// Depends on syb_pkg.
`default_nettype none

module syb_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s_valid,
  output logic           s_ready,
  input  syb_pkg::prep_t s_data,
  output logic           m_valid,
  input  logic           m_ready,
  output syb_pkg::mult_t m_data
);
  import syb_pkg::*;

  logic  valid_r;
  mult_t data_r;
  mult_t data_nxt;
  logic signed [18:0] u_x;
  logic signed [18:0] v_x;
  logic signed [18:0] r_w;
  logic signed [18:0] g_w;
  logic signed [18:0] b_w;

  assign s_ready = !valid_r || m_ready;

  always_comb begin
    u_x = 19'(s_data.u);
    v_x = 19'(s_data.v);
    r_w = RoundBias + CoefRv * v_x;
    g_w = RoundBias - CoefGu * u_x - CoefGv * v_x;
    b_w = RoundBias + CoefBu * u_x;
    for (int i = 0; i < NumPix; i++) begin
      data_nxt.luma_term[i] = 17'(s_data.luma[i]) * LumaCoef;
    end
    // values fit their narrower fields
    data_nxt.term_r = r_w[16:0];
    data_nxt.term_g = g_w[16:0];
    data_nxt.term_b = b_w[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

`default_nettype wire

// ===== hdl/syb_pack.sv =====
// Third pipeline stage: channel sums, clamp to 0..255 and RGB888 packing into the output register.
// Depends on syb_pkg.
`default_nettype none

module syb_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s_valid,
  output logic           s_ready,
  input  syb_pkg::mult_t s_data,
  output logic           m_valid,
  input  logic           m_ready,
  output syb_pkg::pix_t  m_data
);
  import syb_pkg::*;

  logic valid_r;
  pix_t data_r;
  pix_t data_nxt;
  logic signed [18:0] luma_x;
  logic signed [18:0] sum_r;
  logic signed [18:0] sum_g;
  logic signed [18:0] sum_b;

  assign s_ready = !valid_r || m_ready;

  always_comb begin
    luma_x = '0;
    sum_r  = '0;
    sum_g  = '0;
    sum_b  = '0;
    for (int i = 0; i < NumPix; i++) begin
      luma_x = $signed({2'b00, s_data.luma_term[i]});
      sum_r  = luma_x + 19'(s_data.term_r);
      sum_g  = luma_x + 19'(s_data.term_g);
      sum_b  = luma_x + 19'(s_data.term_b);
      data_nxt.rgb[i] = {clamp_chan(sum_r), clamp_chan(sum_g), clamp_chan(sum_b)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

`default_nettype wire

// ===== hdl/semiplanar_yuv_block_to_rgb.sv =====
// YUV 4:2:0 semiplanar (NV12/NV21) 2x2 block to four RGB888 pixels, BT.601 integer maths.
// Input acceptance and out_valid are separated by the offset, multiply and sum/clamp stage registers.
// Throughput one block per clock while out_ready is high; each stage holds its word and loads when downstream frees it.
// Synchronous active-low reset empties the pipeline and sets chroma_order to 0 (NV12).
// Depends on syb_pkg, syb_prep, syb_mult, syb_pack and the assertion macro header.
`default_nettype none
`include "semiplanar_yuv_block_to_rgb_macros.svh"

module semiplanar_yuv_block_to_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_chroma_order,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_luma_top_left,
  input  logic [7:0]  in_luma_top_right,
  input  logic [7:0]  in_luma_bottom_left,
  input  logic [7:0]  in_luma_bottom_right,
  input  logic [7:0]  in_chroma_first,
  input  logic [7:0]  in_chroma_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_rgb_top_left,
  output logic [23:0] out_rgb_top_right,
  output logic [23:0] out_rgb_bottom_left,
  output logic [23:0] out_rgb_bottom_right
);
  import syb_pkg::*;

  logic  chroma_order_r;
  raw_t  raw_word;
  logic  prep_valid;
  logic  prep_ready;
  prep_t prep_word;
  logic  mult_valid;
  logic  mult_ready;
  mult_t mult_word;
  pix_t  pix_word;
  logic  luma_in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_order_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      chroma_order_r <= cfg_chroma_order;
    end
  end

  assign raw_word.luma[0]       = in_luma_top_left;
  assign raw_word.luma[1]       = in_luma_top_right;
  assign raw_word.luma[2]       = in_luma_bottom_left;
  assign raw_word.luma[3]       = in_luma_bottom_right;
  assign raw_word.chroma_first  = in_chroma_first;
  assign raw_word.chroma_second = in_chroma_second;

  syb_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .chroma_order (chroma_order_r),
    .s_valid      (in_valid),
    .s_ready      (in_ready),
    .s_data       (raw_word),
    .m_valid      (prep_valid),
    .m_ready      (prep_ready),
    .m_data       (prep_word)
  );

  syb_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (prep_valid),
    .s_ready (prep_ready),
    .s_data  (prep_word),
    .m_valid (mult_valid),
    .m_ready (mult_ready),
    .m_data  (mult_word)
  );

  syb_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (mult_valid),
    .s_ready (mult_ready),
    .s_data  (mult_word),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_data  (pix_word)
  );

  assign out_rgb_top_left     = pix_word.rgb[0];
  assign out_rgb_top_right    = pix_word.rgb[1];
  assign out_rgb_bottom_left  = pix_word.rgb[2];
  assign out_rgb_bottom_right = pix_word.rgb[3];

  assign luma_in_range = (mult_word.luma_term[0] <= LumaMax) &&
                         (mult_word.luma_term[1] <= LumaMax) &&
                         (mult_word.luma_term[2] <= LumaMax) &&
                         (mult_word.luma_term[3] <= LumaMax);

  // with the sink ready every stage can move, so the pipeline never throttles
  `SYB_ASSERT_IMPLY(a_no_backpressure, clk, rst_n, out_ready, in_ready)
  // a scaled word with a free output register lands there next cycle
  `SYB_ASSERT_NEXT(a_mult_to_out, clk, rst_n, mult_valid && out_ready, out_valid)
  // floored luma never exceeds 239, so its scaled term stays bounded
  `SYB_ASSERT_IMPLY(a_luma_bound, clk, rst_n, mult_valid, luma_in_range)

endmodule

`default_nettype wire

// ===== bench/tb_semiplanar_yuv_block_to_rgb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the NV12/NV21 2x2 block to RGB888 converter.
// Predicts each output word from the input word and the chroma order bit;
// needs only the RTL (semiplanar_yuv_block_to_rgb, its package, its stage modules and the macro header).

module tb_semiplanar_yuv_block_to_rgb;

  typedef enum logic {
    ORDER_NV12 = 1'b0,
    ORDER_NV21 = 1'b1
  } chroma_order_e;

  // luma index: 0 top left, 1 top right, 2 bottom left, 3 bottom right
  typedef struct packed {
    logic [3:0][7:0] luma;
    logic [7:0]      chroma_first;
    logic [7:0]      chroma_second;
  } yuv_block_t;

  typedef logic [3:0][23:0] rgb_quad_t;

  localparam int  DrainPad       = 8;
  localparam int  LongHoldCycles = 300;
  localparam int  RandomPerPhase = 500;
  localparam real TimeoutNs      = 5_000_000.0;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic        cfg_chroma_order = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [7:0]  in_luma_top_left     = 8'd0;
  logic [7:0]  in_luma_top_right    = 8'd0;
  logic [7:0]  in_luma_bottom_left  = 8'd0;
  logic [7:0]  in_luma_bottom_right = 8'd0;
  logic [7:0]  in_chroma_first      = 8'd0;
  logic [7:0]  in_chroma_second     = 8'd0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [23:0] out_rgb_top_left;
  logic [23:0] out_rgb_top_right;
  logic [23:0] out_rgb_bottom_left;
  logic [23:0] out_rgb_bottom_right;

  semiplanar_yuv_block_to_rgb dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_chroma_order     (cfg_chroma_order),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_luma_top_left     (in_luma_top_left),
    .in_luma_top_right    (in_luma_top_right),
    .in_luma_bottom_left  (in_luma_bottom_left),
    .in_luma_bottom_right (in_luma_bottom_right),
    .in_chroma_first      (in_chroma_first),
    .in_chroma_second     (in_chroma_second),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_rgb_top_left     (out_rgb_top_left),
    .out_rgb_top_right    (out_rgb_top_right),
    .out_rgb_bottom_left  (out_rgb_bottom_left),
    .out_rgb_bottom_right (out_rgb_bottom_right)
  );

  always #5 clk = ~clk;

  yuv_block_t    pending_blocks[$];
  rgb_quad_t     rgb_expect_q[$];
  chroma_order_e model_order = ORDER_NV12;
  string         pix_name[4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};

  int   fail_count      = 0;
  int   blocks_accepted = 0;
  int   long_hold_at    = 32'h7fff_ffff;
  bit   long_hold_done  = 1'b0;
  int   hold_left       = 0;
  int   tx_gap_max      = 0;
  int   rx_stall_pct    = 0;
  int   burst_left      = 0;
  int   gap_left        = 0;
  bit   in_fired        = 1'b0;
  logic send_next;

  yuv_block_t cur_block;
  yuv_block_t seen_block;
  rgb_quad_t  got_rgb;
  rgb_quad_t  want_rgb;

  function automatic logic [7:0] sat_chan(input int s);
    if (s <= 0) return 8'h00;
    if (s >= 65535) return 8'hFF;
    return 8'(s >>> 8);
  endfunction

  // BT.601 integer conversion of one block under the given chroma order
  function automatic rgb_quad_t convert_block(input yuv_block_t blk, input chroma_order_e ord);
    int        u, v, cr, cg, cb, yt;
    rgb_quad_t q;
    if (ord == ORDER_NV21) begin
      v = int'(blk.chroma_first) - 128;
      u = int'(blk.chroma_second) - 128;
    end else begin
      u = int'(blk.chroma_first) - 128;
      v = int'(blk.chroma_second) - 128;
    end
    cr = 128 + 409 * v;
    cg = 128 - 100 * u - 208 * v;
    cb = 128 + 516 * u;
    for (int i = 0; i < 4; i++) begin
      yt = int'(blk.luma[i]) - 16;
      yt = (yt > 0) ? 298 * yt : 0;
      q[i] = {sat_chan(yt + cr), sat_chan(yt + cg), sat_chan(yt + cb)};
    end
    return q;
  endfunction

  // half the time a value near a clamp or offset boundary
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges[10] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127,
                              8'd128, 8'd129, 8'd240, 8'd255};
    if ($urandom_range(0, 1) == 0) return edges[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_block(input logic [7:0] tl, tr, bl, br, c0, c1);
    yuv_block_t b;
    b.luma          = {br, bl, tr, tl};
    b.chroma_first  = c0;
    b.chroma_second = c1;
    pending_blocks.push_back(b);
  endtask

  task automatic push_directed();
    push_block(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    push_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    push_block(8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd128);
    push_block(8'd17,  8'd15,  8'd235, 8'd240, 8'd128, 8'd128);
    push_block(8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd255);
    push_block(8'd255, 8'd0,   8'd0,   8'd255, 8'd255, 8'd0);
    push_block(8'd128, 8'd64,  8'd200, 8'd16,  8'd128, 8'd0);
    push_block(8'd128, 8'd64,  8'd200, 8'd16,  8'd0,   8'd128);
    push_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd240, 8'd16);
    push_block(8'd81,  8'd145, 8'd41,  8'd210, 8'd90,  8'd240);
    push_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0);
    push_block(8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255);
  endtask

  task automatic push_random(input int n);
    repeat (n) push_block(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                          pick_byte(), pick_byte());
  endtask

  // test sequence holds back until every word has come out and the pipe is quiet
  task automatic wait_drained();
    while (pending_blocks.size() != 0 || in_valid || rgb_expect_q.size() != 0)
      @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  task automatic write_chroma_order(input chroma_order_e ord);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_chroma_order <= ord;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    model_order = ord;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    if (rst_n) begin
      send_next = in_valid && !in_fired;
      if (!send_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_blocks.size() != 0) begin
          cur_block = pending_blocks.pop_front();
          send_next = 1'b1;
          in_luma_top_left     <= cur_block.luma[0];
          in_luma_top_right    <= cur_block.luma[1];
          in_luma_bottom_left  <= cur_block.luma[2];
          in_luma_bottom_right <= cur_block.luma[3];
          in_chroma_first      <= cur_block.chroma_first;
          in_chroma_second     <= cur_block.chroma_second;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
          end
        end
      end
      in_valid <= send_next;
    end
  end

  // receiver: random stalls, plus one long hold-off to back the pipe up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && blocks_accepted >= long_hold_at) begin
      long_hold_done = 1'b1;
      hold_left      = LongHoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    in_fired = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_fired = 1'b1;
        seen_block.luma = {in_luma_bottom_right, in_luma_bottom_left,
                           in_luma_top_right, in_luma_top_left};
        seen_block.chroma_first  = in_chroma_first;
        seen_block.chroma_second = in_chroma_second;
        rgb_expect_q.push_back(convert_block(seen_block, model_order));
        blocks_accepted++;
      end
      if (out_valid && out_ready) begin
        got_rgb = {out_rgb_bottom_right, out_rgb_bottom_left,
                   out_rgb_top_right, out_rgb_top_left};
        if (rgb_expect_q.size() == 0) begin
          $display("%0t: output word with none expected, actual %h", $time, got_rgb);
          fail_count++;
        end else begin
          want_rgb = rgb_expect_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got_rgb[i] !== want_rgb[i]) begin
              $display("%0t: rgb_%s expected %h actual %h", $time, pix_name[i],
                       want_rgb[i], got_rgb[i]);
              fail_count++;
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed words, reset order first, then NV21
    push_directed();
    wait_drained();
    write_chroma_order(ORDER_NV21);
    push_directed();
    wait_drained();

    // back to back, receiver always ready
    write_chroma_order(ORDER_NV12);
    tx_gap_max   = 0;
    rx_stall_pct = 0;
    push_random(RandomPerPhase);
    wait_drained();

    // both sides idle at random; order rewritten with the same value
    write_chroma_order(ORDER_NV21);
    write_chroma_order(ORDER_NV21);
    tx_gap_max   = 6;
    rx_stall_pct = 30;
    push_random(RandomPerPhase);
    wait_drained();

    // sender flat out while the receiver holds off for a long stretch
    write_chroma_order(ORDER_NV12);
    tx_gap_max   = 0;
    rx_stall_pct = 10;
    long_hold_at = blocks_accepted + 100;
    push_random(RandomPerPhase);
    wait_drained();

    // heavy stalling on the output
    write_chroma_order(ORDER_NV21);
    tx_gap_max   = 3;
    rx_stall_pct = 70;
    push_random(RandomPerPhase);
    wait_drained();

    if (fail_count == 0) begin
      $display("** semiplanar_yuv_block_to_rgb: PASSED **");
    end else begin
      $display("** semiplanar_yuv_block_to_rgb: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("%0t: timed out", $time);
    $display("** semiplanar_yuv_block_to_rgb: FAILED **");
    $finish;
  end

endmodule

// ===== semiplanar_yuv_block_to_rgb.f =====
+incdir+hdl
hdl/syb_pkg.sv
hdl/syb_prep.sv
hdl/syb_mult.sv
hdl/syb_pack.sv
hdl/semiplanar_yuv_block_to_rgb.sv
bench/tb_semiplanar_yuv_block_to_rgb.sv
